// ===== hw/rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package bdpc_pkg;

   localparam int HOLD_COUNT_WIDTH_DEF = 16;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_MAX_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TICKS = 2'd2;

   localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd15;
   localparam logic [15:0] SHORT_MAX_TICKS_RST  = 16'd1000;
   localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd3000;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] short_max_ticks;
      logic [15:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic stable_level;
      logic press_event;
      logic release_event;
      logic short_press_event;
      logic long_press_event;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bdpc_csr.sv =====
// Configuration registers of the press classifier: debounce, short and long limits.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bdpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output bdpc_pkg::cfg_type                         cfg
);
   import bdpc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS:   cfg_in.debounce_ticks   = csr_wdata[7:0];
            CSR_SHORT_MAX_TICKS:  cfg_in.short_max_ticks  = csr_wdata[15:0];
            CSR_LONG_PRESS_TICKS: cfg_in.long_press_ticks = csr_wdata[15:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_TICKS_RST;
         cfg_ff.short_max_ticks  <= SHORT_MAX_TICKS_RST;
         cfg_ff.long_press_ticks <= LONG_PRESS_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/bdpc_core.sv =====
// Debounce and press classification state; one tick is processed per accepted transaction.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_core #(
   parameter int HOLD_COUNT_WIDTH = bdpc_pkg::HOLD_COUNT_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic              pin_level,
   input  wire bdpc_pkg::cfg_type cfg,
   output bdpc_pkg::rsp_type      rsp
);
   import bdpc_pkg::*;

   localparam int CmpW = (HOLD_COUNT_WIDTH > 16) ? HOLD_COUNT_WIDTH : 16;
   localparam logic [HOLD_COUNT_WIDTH-1:0] HoldMax = '1;

   logic                        sampled_ff,  sampled_in;
   logic                        settling_ff, settling_in;
   logic [7:0]                  settle_ff,   settle_in;
   logic                        accepted_ff, accepted_in;  // also the prior level
   logic                        armed_ff,    armed_in;
   logic [HOLD_COUNT_WIDTH-1:0] hold_ff,     hold_in;
   logic [HOLD_COUNT_WIDTH-1:0] hold_inc;

   always_comb begin
      sampled_in  = sampled_ff;
      settling_in = settling_ff;
      settle_in   = settle_ff;
      accepted_in = accepted_ff;
      armed_in    = armed_ff;
      rsp         = '0;

      hold_inc = hold_ff;
      if (accepted_ff && hold_ff != HoldMax)
         hold_inc = hold_ff + 1'b1;
      hold_in = hold_inc;

      if (pin_level != sampled_ff) begin
         sampled_in  = pin_level;
         settling_in = 1'b1;
         settle_in   = '0;
      end else if (settling_ff) begin
         if (settle_ff >= cfg.debounce_ticks) begin
            accepted_in = sampled_ff;
            settling_in = 1'b0;
         end else begin
            settle_in = settle_ff + 8'd1;
         end
      end

      if (accepted_in != accepted_ff) begin
         if (accepted_in) begin
            rsp.press_event = 1'b1;
            armed_in        = 1'b1;
            hold_in         = '0;
         end else begin
            rsp.release_event     = 1'b1;
            rsp.short_press_event = (CmpW'(hold_inc) <= CmpW'(cfg.short_max_ticks));
            armed_in              = 1'b0;
         end
      end

      if (armed_in && CmpW'(hold_in) >= CmpW'(cfg.long_press_ticks)) begin
         rsp.long_press_event = 1'b1;
         armed_in             = 1'b0;
      end

      rsp.stable_level = accepted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff  <= 1'b0;
         settling_ff <= 1'b0;
         settle_ff   <= '0;
         accepted_ff <= 1'b0;
         armed_ff    <= 1'b0;
         hold_ff     <= '0;
      end else if (step) begin
         sampled_ff  <= sampled_in;
         settling_ff <= settling_in;
         settle_ff   <= settle_in;
         accepted_ff <= accepted_in;
         armed_ff    <= armed_in;
         hold_ff     <= hold_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bdpc_skid.sv =====
// Result register with a skid entry, so a transaction can be taken while a result waits.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bdpc_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output bdpc_pkg::rsp_type      out_data
);
   import bdpc_pkg::*;

   logic    out_valid_ff,  out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff,   out_data_in;
   rsp_type skid_data_ff,  skid_data_in;
   logic    push;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Push-button debouncer with press, release, short-press and long-press events.
//
// req_ channel: one transaction per tick carrying the raw button level
// (req_pin_level, 1 = pressed). rsp_ channel: one transaction per request with
// the debounced level and the event flags for that tick, in order.
// csr_ port: write-only; csr_index 0 debounce ticks, 1 short limit, 2 long
// limit, index 3 ignored. Write only while no request is outstanding.
//
// A taken request's result is registered, or held in the skid entry on a stall.
// Throughput: one request per cycle while the skid entry is empty; the tick
// update is a single pass of counters and compares on the state registers.
// Reset clears all state and loads the default limits (15, 1000, 3000); the
// result register and skid entry come up empty.
// When rsp_ready is held low, one more request is taken into the skid entry,
// then req_ready drops until the result register drains.
`default_nettype none

module button_debounce_press_classifier #(
   parameter int HOLD_COUNT_WIDTH = bdpc_pkg::HOLD_COUNT_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_pin_level,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_stable_level,
   output logic                                      rsp_press_event,
   output logic                                      rsp_release_event,
   output logic                                      rsp_short_press_event,
   output logic                                      rsp_long_press_event,
   input  wire logic                                 csr_wr_en,
   input  wire logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bdpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bdpc_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    step;

   assign step = req_valid && req_ready;

   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdpc_core #(
      .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pin_level (req_pin_level),
      .cfg       (cfg),
      .rsp       (step_rsp)
   );

   bdpc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_rsp)
   );

   assign rsp_stable_level      = out_rsp.stable_level;
   assign rsp_press_event       = out_rsp.press_event;
   assign rsp_release_event     = out_rsp.release_event;
   assign rsp_short_press_event = out_rsp.short_press_event;
   assign rsp_long_press_event  = out_rsp.long_press_event;

endmodule

`default_nettype wire
